### rtl/st7s_pkg.sv
// ----------------------------------------------------------------------------
// st7s_pkg
// Shared types, constants and look-up functions for the signed temperature
// to seven-segment display block.
// ----------------------------------------------------------------------------
`default_nettype none

package st7s_pkg;

    // Segment codes (a to g on bits 0 to 6)
    localparam logic [7:0] SEG_MINUS = 8'h40;

    // Range of the display: magnitudes at or above this give no transfers
    localparam int unsigned MAG_LIMIT = 1000;

    // Digit counts of a decoded value
    localparam logic [1:0] NDIG_ONE   = 2'd1;
    localparam logic [1:0] NDIG_TWO   = 2'd2;
    localparam logic [1:0] NDIG_THREE = 2'd3;

    // Display positions
    localparam logic [1:0] POS_LEFT   = 2'd0;
    localparam logic [1:0] POS_HUND   = 2'd1;
    localparam logic [1:0] POS_TENS   = 2'd2;
    localparam logic [1:0] POS_UNITS  = 2'd3;

    // One decoded value, passed from the front end to the back end
    typedef struct packed {
        logic       neg;
        logic [1:0] ndig;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } st7s_entry_t;

    // Decimal digit to segment byte
    function automatic logic [7:0] digit_segments(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Position to active-low cathode select byte
    function automatic logic [7:0] position_cathodes(input logic [1:0] pos);
        logic [7:0] cat;
        case (pos)
            POS_LEFT:  cat = 8'h7F;
            POS_HUND:  cat = 8'hBF;
            POS_TENS:  cat = 8'hDF;
            POS_UNITS: cat = 8'hEF;
            default:   cat = 8'hFF;
        endcase
        return cat;
    endfunction

endpackage

`default_nettype wire

### rtl/st7s_front.sv
// ----------------------------------------------------------------------------
// st7s_front
// Front end: takes sensor words, forms the whole-degree magnitude, drops
// values outside the display range and splits the rest into decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module st7s_front
    import st7s_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              temp_valid,
    output logic                   temp_stall,
    input  wire logic signed [15:0] raw_temp,
    output logic                   push,
    output st7s_entry_t            push_entry,
    input  wire logic              q_full
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_neg_reg;
    logic [11:0] s1_mag_reg;

    logic [11:0] whole;
    logic [11:0] mag_in;
    logic        drop;
    logic        advance;
    logic        take;
    logic [9:0]  mag10;
    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [9:0]  hund_x100;
    logic [6:0]  rem;
    logic [13:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  units;

    // Whole degrees: arithmetic shift by four, then magnitude
    assign whole  = raw_temp[15:4];
    assign mag_in = raw_temp[15] ? (12'd0 - whole) : whole;

    // Stage handshake
    assign drop       = (s1_mag_reg >= 12'(MAG_LIMIT));
    assign advance    = s1_valid_reg && (drop || !q_full);
    assign temp_stall = s1_valid_reg && !advance;
    assign take       = temp_valid && !temp_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_neg_reg <= raw_temp[15];
            s1_mag_reg <= mag_in;
        end
    end

    // Decimal split: reciprocal multiplies, exact below 1000
    assign mag10     = s1_mag_reg[9:0];
    assign hund_prod = 16'(mag10) * 16'd41;
    assign hund      = hund_prod[15:12];
    assign hund_x100 = 10'(hund) * 10'd100;
    assign rem       = 7'(mag10 - hund_x100);
    assign tens_prod = 14'(rem) * 14'd103;
    assign tens      = tens_prod[13:10];
    assign tens_x10  = 7'(tens) * 7'd10;
    assign units     = 4'(rem - tens_x10);

    // Queue write
    assign push            = s1_valid_reg && !drop && !q_full;
    assign push_entry.neg  = s1_neg_reg;
    assign push_entry.ndig = (mag10 < 10'd10)  ? NDIG_ONE :
                             (mag10 < 10'd100) ? NDIG_TWO : NDIG_THREE;
    assign push_entry.hund  = hund;
    assign push_entry.tens  = tens;
    assign push_entry.units = units;

endmodule

`default_nettype wire

### rtl/st7s_queue.sv
// ----------------------------------------------------------------------------
// st7s_queue
// Short first-in first-out queue of decoded values between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module st7s_queue
    import st7s_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire st7s_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output st7s_entry_t      head,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    st7s_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

### rtl/st7s_back.sv
// ----------------------------------------------------------------------------
// st7s_back
// Back end: steps through the lit positions of one decoded value and drives
// one display transfer per cycle through an output register while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module st7s_back
    import st7s_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire st7s_entry_t head,
    input  wire logic        empty,
    output logic             pop,
    output logic             disp_valid,
    input  wire logic        disp_stall,
    output logic [1:0]       position,
    output logic [7:0]       cathode_pattern,
    output logic [7:0]       segment_pattern,
    output logic             last
);

    st7s_entry_t cur_reg;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  pos_reg;
    logic [7:0]  seg_reg;
    logic        last_reg;

    logic        load_out;
    logic        emit;
    logic [2:0]  count;
    logic [1:0]  pos;
    logic [3:0]  digit;
    logic [7:0]  seg;
    logic        is_last;

    // Result for the current step
    always_comb
    begin
        count   = 3'(cur_reg.ndig) + 3'(cur_reg.neg);
        is_last = (3'(idx_reg) == count - 3'd1);
        if (!cur_reg.neg && cur_reg.ndig == NDIG_TWO)
            pos = (idx_reg == 2'd0) ? POS_UNITS : POS_TENS;
        else
            pos = 2'(3'd4 - count + 3'(idx_reg));
        case (pos)
            POS_HUND:  digit = cur_reg.hund;
            POS_TENS:  digit = cur_reg.tens;
            default:   digit = cur_reg.units;
        endcase
        if (cur_reg.neg && idx_reg == 2'd0)
            seg = SEG_MINUS;
        else
            seg = digit_segments(digit);
    end

    // Sequencer control
    assign load_out = !out_valid_reg || !disp_stall;
    assign emit     = busy_reg && load_out;
    assign pop      = !empty && (!busy_reg || (emit && is_last));

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = emit;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (emit)
        begin
            if (is_last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (emit)
        begin
            pos_reg  <= pos;
            seg_reg  <= seg;
            last_reg <= is_last;
        end
    end

    assign disp_valid      = out_valid_reg;
    assign position        = pos_reg;
    assign cathode_pattern = position_cathodes(pos_reg);
    assign segment_pattern = seg_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

### rtl/signed_temp_to_seven_segment.sv
// ----------------------------------------------------------------------------
// signed_temp_to_seven_segment
// Converts a signed 1/16-degree sensor word to the lit positions of a
// four-digit seven-segment display, one transfer per position.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// temp      in         temp_valid/temp_stall   raw_temp[15:0] signed
// disp      out        disp_valid/disp_stall   position, cathode_pattern,
//                                              segment_pattern, last
//
// A word passes through the front register, a queue slot, the sequencer's
// current-value register and the output register before its first display
// transfer is offered; it gives one to four transfers, one per cycle while the
// display does not stall, and the next word is taken up with the last of them.
// Words out of the display range leave the front end with no transfers.
// Reset clears the front register, the queue and the sequencer at once.
// A stalled display holds its transfer; the queue lets the front keep going until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_temp_to_seven_segment
    import st7s_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               temp_valid,
    output logic                    temp_stall,
    input  wire logic signed [15:0] raw_temp,
    output logic                    disp_valid,
    input  wire logic               disp_stall,
    output logic [1:0]              position,
    output logic [7:0]              cathode_pattern,
    output logic [7:0]              segment_pattern,
    output logic                    last
);

    st7s_entry_t push_entry;
    st7s_entry_t head;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;

    st7s_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .temp_valid (temp_valid),
        .temp_stall (temp_stall),
        .raw_temp   (raw_temp),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    st7s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    st7s_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (q_empty),
        .pop             (pop),
        .disp_valid      (disp_valid),
        .disp_stall      (disp_stall),
        .position        (position),
        .cathode_pattern (cathode_pattern),
        .segment_pattern (segment_pattern),
        .last            (last)
    );

endmodule

`default_nettype wire

### rtl/st7s_checker.sv
// ----------------------------------------------------------------------------
// st7s_checker
// Port-level checks of the display channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module st7s_checker
    import st7s_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       disp_valid,
    input  wire logic       disp_stall,
    input  wire logic [1:0] position,
    input  wire logic [7:0] cathode_pattern,
    input  wire logic [7:0] segment_pattern,
    input  wire logic       last
);

    // A stalled transfer stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_stall |=> disp_valid)
        else $error("display transfer withdrawn while stalled");

    // Leftmost position only ever carries a leading minus
    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && position == POS_LEFT |-> segment_pattern == SEG_MINUS && !last)
        else $error("leftmost position not a leading minus");

    // A value always ends on the tens or units position
    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && last |-> position == POS_TENS || position == POS_UNITS)
        else $error("final transfer on wrong position");

    // Cathode select follows the position
    assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid |-> cathode_pattern == position_cathodes(position))
        else $error("cathode select does not match position");

endmodule

bind signed_temp_to_seven_segment st7s_checker u_st7s_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .disp_valid      (disp_valid),
    .disp_stall      (disp_stall),
    .position        (position),
    .cathode_pattern (cathode_pattern),
    .segment_pattern (segment_pattern),
    .last            (last)
);

`default_nettype wire
